FILE: rtl/drct_pkg.sv
package drct_pkg;

    // Sentinels for empty digit history
    localparam logic [3:0] NO_DIGIT = 4'd10;
    localparam logic [6:0] NO_PAIR  = 7'd100;
    localparam logic [4:0] RUN_CAP  = 5'd16;

    // Byte classes kept for the most recent non-digit byte
    localparam logic [3:0] KIND_NUL     = 4'd0;
    localparam logic [3:0] KIND_SPACE   = 4'd1;
    localparam logic [3:0] KIND_LOWER   = 4'd2;
    localparam logic [3:0] KIND_UPPER   = 4'd3;
    localparam logic [3:0] KIND_DIGIT   = 4'd4;
    localparam logic [3:0] KIND_EQUAL   = 4'd5;
    localparam logic [3:0] KIND_ANGLE   = 4'd6;
    localparam logic [3:0] KIND_SIGN    = 4'd7;
    localparam logic [3:0] KIND_SLASH   = 4'd8;
    localparam logic [3:0] KIND_PUNCT   = 4'd9;
    localparam logic [3:0] KIND_COLON   = 4'd10;
    localparam logic [3:0] KIND_OPEN    = 4'd11;
    localparam logic [3:0] KIND_CLOSE   = 4'd12;
    localparam logic [3:0] KIND_QUOTE   = 4'd13;
    localparam logic [3:0] KIND_CONTROL = 4'd14;
    localparam logic [3:0] KIND_OTHER   = 4'd15;

    // Tracker state, passed between the update logic and the encoder
    typedef struct packed {
        logic       in_run;
        logic [4:0] run_count;
        logic [3:0] last_digit;
        logic [6:0] last_pair;
        logic [3:0] left_kind;
    } t_state;

    localparam t_state STATE_RESET = '{
        in_run:     1'b0,
        run_count:  5'd0,
        last_digit: NO_DIGIT,
        last_pair:  NO_PAIR,
        left_kind:  KIND_NUL
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // 16-way byte class
    function automatic logic [3:0] class_of(input logic [7:0] b);
        logic [3:0] k;
        priority if (b == 8'h00)                                   k = KIND_NUL;
        else if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A)
                                                                   k = KIND_SPACE;
        else if (b >= 8'h61 && b <= 8'h7A)                         k = KIND_LOWER;
        else if (b >= 8'h41 && b <= 8'h5A)                         k = KIND_UPPER;
        else if (b >= 8'h30 && b <= 8'h39)                         k = KIND_DIGIT;
        else if (b == 8'h3D)                                       k = KIND_EQUAL;
        else if (b == 8'h3C || b == 8'h3E)                         k = KIND_ANGLE;
        else if (b == 8'h2B || b == 8'h2D)                         k = KIND_SIGN;
        else if (b == 8'h2F || b == 8'h5C)                         k = KIND_SLASH;
        else if (b == 8'h2E || b == 8'h2C)                         k = KIND_PUNCT;
        else if (b == 8'h3A || b == 8'h3B)                         k = KIND_COLON;
        else if (b == 8'h28 || b == 8'h5B || b == 8'h7B)           k = KIND_OPEN;
        else if (b == 8'h29 || b == 8'h5D || b == 8'h7D)           k = KIND_CLOSE;
        else if (b == 8'h27 || b == 8'h22)                         k = KIND_QUOTE;
        else if (b < 8'h20 || b == 8'h7F)                          k = KIND_CONTROL;
        else                                                       k = KIND_OTHER;
        return k;
    endfunction

    // Run length bucket: 0..5 direct, then 6-7, 8-9, 10-15, 16
    function automatic logic [3:0] bucket_of(input logic [4:0] n);
        logic [3:0] bk;
        priority if (n <= 5'd5) bk = n[3:0];
        else if (n <= 5'd7)     bk = 4'd6;
        else if (n <= 5'd9)     bk = 4'd7;
        else if (n <= 5'd15)    bk = 4'd8;
        else                    bk = 4'd9;
        return bk;
    endfunction

endpackage

FILE: rtl/digit_run_context_tracker_core.sv
// Digit run context tracker.
// Input channel: i_valid / o_ready with i_byte_in, one byte per item.
// Output channel: o_valid / i_ready with o_context_value, one context per byte.
// Each accepted byte updates the run state (run flag, run length, last digit,
// last digit pair, class of last non-digit byte) in the same cycle; the state
// register doubles as the stage holding that byte's snapshot.
// The snapshot is encoded into the output register when the state stage moves.
// Throughput: 1 item per cycle while the receiver keeps i_ready high, set by
// the state update loop through the state register.
// The state stage advances whenever the output register is empty or being
// taken, so a stalled receiver backs up through o_ready after two items.
// Reset (synchronous, i_rst_n low): run flag and length cleared, digit and
// pair set to "none", class set to NUL, both stages emptied.
module digit_run_context_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [18:0] o_context_value
);

    drct_pkg::t_state r_state, n_state;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic [18:0]      r_context;
    logic [18:0]      w_context;
    logic             w_in_fire;
    logic             w_s1_move;

    // Stage handshake
    assign w_s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_in_fire = i_valid && o_ready;

    drct_update u_update (
        .i_byte  (i_byte_in),
        .i_state (r_state),
        .o_state (n_state)
    );

    drct_encode u_encode (
        .i_state   (r_state),
        .o_context (w_context)
    );

    // State update and snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= drct_pkg::STATE_RESET;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_state <= n_state;
            end
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_context <= w_context;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_context_value = r_context;

endmodule

FILE: rtl/drct_update.sv
module drct_update (
    input  logic [7:0]      i_byte,
    input  drct_pkg::t_state i_state,
    output drct_pkg::t_state o_state
);

    logic [3:0] w_digit;
    logic [6:0] w_pair;

    assign w_digit = i_byte[3:0] - 4'd0;
    // previous digit is always 0..9 inside a run, so the pair stays below 100
    assign w_pair  = 7'(i_state.last_digit) * 7'd10 + 7'(w_digit);

    // Next state for one byte
    always_comb begin
        o_state = i_state;
        if (drct_pkg::is_digit(i_byte)) begin
            if (!i_state.in_run) begin
                o_state.in_run     = 1'b1;
                o_state.run_count  = 5'd1;
                o_state.last_digit = w_digit;
                o_state.last_pair  = 7'(w_digit);
            end else begin
                if (i_state.run_count < drct_pkg::RUN_CAP) begin
                    o_state.run_count = i_state.run_count + 5'd1;
                end
                o_state.last_pair  = w_pair;
                o_state.last_digit = w_digit;
            end
        end else begin
            o_state.in_run     = 1'b0;
            o_state.run_count  = 5'd0;
            o_state.last_digit = drct_pkg::NO_DIGIT;
            o_state.last_pair  = drct_pkg::NO_PAIR;
            o_state.left_kind  = drct_pkg::class_of(i_byte);
        end
    end

endmodule

FILE: rtl/drct_encode.sv
module drct_encode (
    input  drct_pkg::t_state i_state,
    output logic [18:0]      o_context
);

    logic [4:0]  w_run_bucket;
    logic [7:0]  w_with_digit;
    logic [14:0] w_with_pair;

    // Mixed radix 2 x 10 x 11 x 101 x 16, constant multiplies only
    assign w_run_bucket = 5'(i_state.in_run) * 5'd10
                        + 5'(drct_pkg::bucket_of(i_state.run_count));
    assign w_with_digit = 8'(w_run_bucket) * 8'd11 + 8'(i_state.last_digit);
    assign w_with_pair  = 15'(w_with_digit) * 15'd101 + 15'(i_state.last_pair);
    assign o_context    = {w_with_pair, i_state.left_kind};

endmodule
